// ===== design/cfa_pkg.sv =====
`timescale 1ns / 1ps
package cfa_pkg;
	localparam int unsigned DataWidth = 64;
	localparam int unsigned FracBits = 52;
	localparam int unsigned ExpBits = 11;
	localparam logic [10:0] ExpMax = 11'h7ff;
	localparam logic [63:0] LossLimitReset = 64'h100000;
	localparam logic [63:0] QnanBits = 64'h7FF8000000000000;

	typedef logic [63:0] word_t;

	// special-case decode carried down the pipeline
	typedef struct packed {
		logic       special;
		logic [63:0] special_val;
		logic       loss;
	} ctl_t;

	// count leading zeros of a 56-bit mantissa (priority search)
	function automatic logic [5:0] clz56(input logic [55:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd56;
		found = 1'b0;
		for (int i = 55; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(55 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction
endpackage

// ===== design/cfa_stream_if.sv =====
`timescale 1ns / 1ps
interface cfa_stream_if #(parameter int unsigned Width = 64);
	logic             valid;
	logic             ready;
	logic [Width-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/cfa_in_if.sv =====
`timescale 1ns / 1ps
interface cfa_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] a_bits;
	logic [63:0] b_bits;
	modport source (output valid, output a_bits, output b_bits, input ready);
	modport sink (input valid, input a_bits, input b_bits, output ready);
endinterface

// ===== design/cfa_out_if.sv =====
`timescale 1ns / 1ps
interface cfa_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] sum_bits;
	logic        loss_flag;
	modport source (output valid, output sum_bits, output loss_flag, input ready);
	modport sink (input valid, input sum_bits, input loss_flag, output ready);
endinterface

// ===== design/checked_fp64_adder.sv =====
`timescale 1ns / 1ps
// channel | dir | payload             | accepted when
// in      | in  | a_bits, b_bits      | in.valid && in.ready
// out     | out | sum_bits, loss_flag | out.valid && out.ready
// cfg     | in  | data (loss_limit)   | cfg.valid && cfg.ready
// Four register stages: align/check, add, normalize, round. One request enters
// every cycle while the output is not stalled. Reset clears valid bits and sets
// loss_limit to 0x100000. A stall at the output holds the whole pipeline.
module checked_fp64_adder (
	input  logic        clk,
	input  logic        arst_n,
	cfa_in_if.sink      in,
	cfa_out_if.source   out,
	cfa_stream_if.sink  cfg
);
	import cfa_pkg::*;

	logic        adv;
	logic [63:0] loss_limit_q;

	assign adv = !out.valid || out.ready;
	assign in.ready = adv;
	assign cfg.ready = 1'b1;

	// hold the loss limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) loss_limit_q <= LossLimitReset;
		else if (cfg.valid) loss_limit_q <= cfg.data;
	end

	// ---- stage 1: unpack, order, align, loss check
	logic        sa, sb, sl, ss;
	logic [10:0] ea, eb, el, esm, dab, dba;
	logic [51:0] fa, fb;
	logic [55:0] ma, mb, ml, msm, msh;
	logic [63:0] dropped, mk;
	logic [11:0] dd;
	logic        swap, stk;
	ctl_t        ctl_c;
	logic        v_s1, v_s2, v_s3, v_s4;
	ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic        sgn_s1, eff_sub_s1;
	logic [10:0] e_s1;
	logic [55:0] ml_s1, ms_s1;

	always_comb begin
		sa = in.a_bits[63]; sb = in.b_bits[63];
		ea = in.a_bits[62:52]; eb = in.b_bits[62:52];
		fa = in.a_bits[51:0]; fb = in.b_bits[51:0];
		dab = ea - eb; dba = eb - ea;
		dropped = '0;
		if (ea > eb) begin
			mk = (dab >= 11'd64) ? '1 : ((64'd1 << dab[5:0]) - 64'd1);
			dropped = mk & in.b_bits;
		end else begin
			mk = (dba >= 11'd64) ? '1 : ((64'd1 << dba[5:0]) - 64'd1);
			if (eb > ea) dropped = mk & in.a_bits;
		end
		ctl_c.loss = dropped > loss_limit_q;
		ctl_c.special = 1'b1;
		ctl_c.special_val = '0;
		if ((ea == ExpMax && fa != '0) || (eb == ExpMax && fb != '0))
			ctl_c.special_val = QnanBits;
		else if (ea == ExpMax && eb == ExpMax)
			ctl_c.special_val = (sa == sb) ? in.a_bits : QnanBits;
		else if (ea == ExpMax)
			ctl_c.special_val = in.a_bits;
		else if (eb == ExpMax)
			ctl_c.special_val = in.b_bits;
		else
			ctl_c.special = 1'b0;
		ma = {(ea != '0), fa, 3'b000};
		mb = {(eb != '0), fb, 3'b000};
		if (ea == '0) ea = 11'd1;
		if (eb == '0) eb = 11'd1;
		swap = (eb > ea) || (eb == ea && mb > ma);
		ml = swap ? mb : ma; msm = swap ? ma : mb;
		el = swap ? eb : ea; esm = swap ? ea : eb;
		sl = swap ? sb : sa; ss = swap ? sa : sb;
		dd = {1'b0, el - esm};
		stk = 1'b0;
		if (dd >= 12'd58) msh = {55'd0, (msm != '0)};
		else begin
			stk = |(msm & ((56'd1 << dd[5:0]) - 56'd1));
			msh = (msm >> dd[5:0]) | {55'd0, stk};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_c; sgn_s1 <= sl; eff_sub_s1 <= (sl != ss);
			e_s1 <= el; ml_s1 <= ml; ms_s1 <= msh;
		end
	end

	// ---- stage 2: add or subtract
	logic [56:0] sum_c;
	logic [55:0] m_s2;
	logic [11:0] e_s2;
	logic        sgn_s2, zero_s2, sub_s2;
	always_comb sum_c = eff_sub_s1 ? ({1'b0, ml_s1} - {1'b0, ms_s1})
	                               : ({1'b0, ml_s1} + {1'b0, ms_s1});
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1; sgn_s2 <= sgn_s1; sub_s2 <= eff_sub_s1;
			zero_s2 <= eff_sub_s1 && (sum_c == '0);
			if (sum_c[56]) begin
				m_s2 <= sum_c[56:1] | {55'd0, sum_c[0]};
				e_s2 <= {1'b0, e_s1} + 12'd1;
			end else begin
				m_s2 <= sum_c[55:0];
				e_s2 <= {1'b0, e_s1};
			end
		end
	end

	// ---- stage 3: normalize after cancellation
	logic [5:0]  lz, sh;
	logic [55:0] m_s3;
	logic [11:0] e_s3;
	logic        sgn_s3, zero_s3;
	always_comb begin
		lz = clz56(m_s2) - 6'd0;
		if (lz > 6'd0) lz = lz - 6'd0;
		sh = 6'd0;
		if (sub_s2 && m_s2[55] == 1'b0) begin
			// shift by leading zeros below bit 55, bounded so exponent stays >= 1
			sh = lz;
			if ({6'd0, lz} > e_s2 - 12'd1) sh = 6'(e_s2 - 12'd1);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_s2; sgn_s3 <= sgn_s2; zero_s3 <= zero_s2;
			m_s3 <= m_s2 << sh;
			e_s3 <= e_s2 - {6'd0, sh};
		end
	end

	// ---- stage 4: round, pack, select
	logic [53:0] r;
	logic [11:0] er;
	logic [63:0] res;
	logic        rup;
	logic [63:0] sum_s4;
	logic        loss_s4;
	always_comb begin
		rup = (m_s3[2:0] > 3'd4) || (m_s3[2:0] == 3'd4 && m_s3[3]);
		r = {1'b0, m_s3[55:3]} + {53'd0, rup};
		er = e_s3;
		if (r[53]) begin
			r = r >> 1;
			er = er + 12'd1;
		end
		if (er >= {1'b0, ExpMax}) res = {sgn_s3, ExpMax, 52'd0};
		else if (r[52]) res = {sgn_s3, er[10:0], r[51:0]};
		else res = {sgn_s3, 11'd0, r[51:0]};
		if (zero_s3) res = '0;
		if (ctl_s3.special) res = ctl_s3.special_val;
		if (ctl_s3.loss) res = '0;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= res; loss_s4 <= ctl_s3.loss;
		end
	end

	assign out.valid = v_s4;
	assign out.sum_bits = sum_s4;
	assign out.loss_flag = loss_s4;
endmodule

// ===== bench/checked_fp64_adder_tb.sv =====
`timescale 1ns / 1ps
module checked_fp64_adder_tb;
	import cfa_pkg::*;

	typedef struct {
		logic [63:0] a;
		logic [63:0] b;
		logic        known;
		logic [63:0] sum;
		logic        loss;
	} vec_t;

	typedef struct {
		logic [63:0] sum;
		logic        loss;
	} sum_t;

	logic clk;
	logic arst_n;
	int unsigned cycles;
	int unsigned errors;
	bit tail_phase;
	logic [63:0] limit_q;
	sum_t sums_pending[$];
	vec_t dir_tab[$];

	cfa_in_if in_ch();
	cfa_out_if out_ch();
	cfa_stream_if #(.Width(64)) cfg_ch();

	checked_fp64_adder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source),
		.cfg(cfg_ch.sink)
	);

	// drive the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cap the run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [63:0] mask_low(input int unsigned n);
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	// compute the rounded binary64 sum
	function automatic logic [63:0] add_fp(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] sa, sb, fa, fb, ma, mb, m, t;
		int ea, eb, d, e;
		logic [2:0] low3;
		sa = {a[63], 63'd0};
		sb = {b[63], 63'd0};
		ea = int'(a[62:52]);
		eb = int'(b[62:52]);
		fa = {12'd0, a[51:0]};
		fb = {12'd0, b[51:0]};
		if ((ea == ExpMax && fa != 0) || (eb == ExpMax && fb != 0))
			return QnanBits;
		if (ea == ExpMax && eb == ExpMax)
			return (sa == sb) ? a : QnanBits;
		if (ea == ExpMax)
			return a;
		if (eb == ExpMax)
			return b;
		ma = (ea == 0) ? fa : (fa | (64'd1 << 52));
		mb = (eb == 0) ? fb : (fb | (64'd1 << 52));
		if (ea == 0) ea = 1;
		if (eb == 0) eb = 1;
		ma = ma << 3;
		mb = mb << 3;
		// order by magnitude
		if (eb > ea || (eb == ea && mb > ma)) begin
			t = ma; ma = mb; mb = t;
			d = ea; ea = eb; eb = d;
			t = sa; sa = sb; sb = t;
		end
		d = ea - eb;
		if (d >= 58)
			mb = (mb != 0) ? 64'd1 : 64'd0;
		else if (d > 0)
			mb = (mb >> d) | (((mb & mask_low(d)) != 0) ? 64'd1 : 64'd0);
		e = ea;
		if (sa == sb) begin
			m = ma + mb;
			if (m[56]) begin
				m = (m >> 1) | (m & 64'd1);
				e++;
			end
		end else begin
			m = ma - mb;
			if (m == 0)
				return 64'd0;
			while (m < (64'd1 << 55) && e > 1) begin
				m = m << 1;
				e--;
			end
		end
		low3 = m[2:0];
		m = m >> 3;
		if (low3 > 4 || (low3 == 4 && m[0]))
			m++;
		if (m[53]) begin
			m = m >> 1;
			e++;
		end
		if (e >= ExpMax)
			return sa | ({53'd0, ExpMax} << 52);
		if (m[52])
			return sa | (64'(e) << 52) | {12'd0, m[51:0]};
		return sa | {12'd0, m[51:0]};
	endfunction

	function automatic sum_t predict_sum(input logic [63:0] a, input logic [63:0] b);
		sum_t r;
		int unsigned ea, eb;
		logic [63:0] dropped;
		ea = 32'(a[62:52]);
		eb = 32'(b[62:52]);
		dropped = '0;
		if (ea > eb)
			dropped = mask_low(ea - eb) & b;
		else if (eb > ea)
			dropped = mask_low(eb - ea) & a;
		if (dropped > limit_q) begin
			r.sum = '0;
			r.loss = 1'b1;
		end else begin
			r.sum = add_fp(a, b);
			r.loss = 1'b0;
		end
		return r;
	endfunction

	// drop valid for a random gap unless the tail runs
	task automatic idle_burst();
		if (!tail_phase && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
	endtask

	task automatic send_request(input logic [63:0] a, input logic [63:0] b);
		idle_burst();
		in_ch.valid <= 1'b1;
		in_ch.a_bits <= a;
		in_ch.b_bits <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sums_pending.push_back(predict_sum(a, b));
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sums_pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(input logic [63:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		limit_q = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random operand, mostly with small exponent spread from base
	function automatic logic [63:0] rand_operand(input int unsigned base);
		logic [63:0] v;
		int unsigned ex;
		v = rand64();
		case ($urandom_range(0, 9))
			0: ex = 0;
			1: ex = 11'h7ff;
			2: ex = $urandom_range(0, 2047);
			3: ex = (base > 2040) ? 2046 : base + $urandom_range(0, 6);
			default: ex = base + $urandom_range(0, 1);
		endcase
		if (ex > 2047) ex = 2047;
		v[62:52] = ex[10:0];
		if ($urandom_range(0, 3) == 0) v[19:0] = '0;
		return v;
	endfunction

	// check each result against the oldest prediction
	always @(posedge clk) begin
		sum_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (sums_pending.size() == 0) begin
				$error("unexpected result sum_bits=%h", out_ch.sum_bits);
				errors++;
			end else begin
				want = sums_pending.pop_front();
				if (out_ch.sum_bits !== want.sum) begin
					$error("sum_bits expected %h actual %h", want.sum, out_ch.sum_bits);
					errors++;
				end
				if (out_ch.loss_flag !== want.loss) begin
					$error("loss_flag expected %b actual %b", want.loss, out_ch.loss_flag);
					errors++;
				end
			end
		end
	end

	// stall the result side in bursts
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!tail_phase && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	function automatic vec_t row(input logic [63:0] a, input logic [63:0] b,
			input logic known, input logic [63:0] s, input logic l);
		vec_t v;
		v.a = a; v.b = b; v.known = known; v.sum = s; v.loss = l;
		return v;
	endfunction

	initial begin
		logic [63:0] a, b;
		int unsigned base;
		cycles = 0;
		errors = 0;
		tail_phase = 1'b0;
		limit_q = LossLimitReset;
		in_ch.valid = 1'b0;
		in_ch.a_bits = '0;
		in_ch.b_bits = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows; known results only where obvious
		dir_tab.push_back(row(64'h0, 64'h0, 1'b1, 64'h0, 1'b0));
		dir_tab.push_back(row(64'h8000000000000000, 64'h8000000000000000, 1'b1,
			64'h8000000000000000, 1'b0));
		dir_tab.push_back(row(64'h8000000000000000, 64'h0, 1'b1, 64'h0, 1'b0));
		dir_tab.push_back(row(64'h3FF0000000000000, 64'hBFF0000000000000, 1'b1, 64'h0,
			1'b0));
		// NaN against a far smaller exponent: the whole small operand is dropped
		dir_tab.push_back(row(64'h7FF0000000000001, 64'h3FF0000000000000, 1'b1, 64'h0,
			1'b1));
		dir_tab.push_back(row(64'h7FF0000000000000, 64'hFFF0000000000000, 1'b1, QnanBits,
			1'b0));
		dir_tab.push_back(row(64'h7FF0000000000000, 64'h7FF0000000000000, 1'b1,
			64'h7FF0000000000000, 1'b0));
		dir_tab.push_back(row(64'hFFF0000000000000, 64'h4000000000000000, 1'b1,
			64'h0, 1'b1));
		dir_tab.push_back(row(64'h7FEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 1'b1,
			64'h7FF0000000000000, 1'b0));
		dir_tab.push_back(row(64'hFFEFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF, 1'b1,
			64'hFFF0000000000000, 1'b0));
		dir_tab.push_back(row(64'h000FFFFFFFFFFFFF, 64'h0000000000000001, 1'b0, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h0000000000000001, 64'h8000000000000001, 1'b1, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h3FF0000000000000, 64'h3FF0000000000000, 1'b0, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h7FE0000000000000, 64'h00000000FFFFFFFF, 1'b1, 64'h0,
			1'b1));
		dir_tab.push_back(row(64'h7FE0000000000000, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h4340000000000000, 64'h3FF0000000000001, 1'b0, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h3FF0000000000001, 64'h3FF8000000000003, 1'b0, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h3FFFFFFFFFFFFFFF, 64'h3CA0000000000000, 1'b0, 64'h0,
			1'b0));
		dir_tab.push_back(row(64'h3FF0000000000000, 64'hBFEFFFFFFFFFFFFF, 1'b0, 64'h0,
			1'b0));
		foreach (dir_tab[i]) begin
			send_request(dir_tab[i].a, dir_tab[i].b);
			if (dir_tab[i].known && (dir_tab[i].sum !== sums_pending[$].sum ||
					dir_tab[i].loss !== sums_pending[$].loss)) begin
				$error("table row %0d: expected %h/%b, predicted %h/%b", i,
					dir_tab[i].sum, dir_tab[i].loss, sums_pending[$].sum,
					sums_pending[$].loss);
				errors++;
			end
		end
		drain();

		// random phases across limit settings, extremes first
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: write_limit(64'h0);
				1: write_limit(64'hFFFFFFFFFFFFFFFF);
				2: write_limit(LossLimitReset);
				default: write_limit(rand64() >> $urandom_range(0, 63));
			endcase
			if (ph == 6) tail_phase = 1'b1;
			for (int k = 0; k < 150; k++) begin
				base = $urandom_range(0, 2046);
				a = rand_operand(base);
				b = rand_operand(base);
				if ($urandom_range(0, 1)) begin
					a = rand_operand(base);
					b = a;
					b[63] = 1'($urandom_range(0, 1));
					b[19:0] = 20'($urandom());
				end
				send_request(a, b);
				// let the pipeline empty once mid-phase
				if (ph == 3 && k == 70) begin
					in_ch.valid <= 1'b0;
					while (sums_pending.size() != 0) @(negedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
